@@ sv/bfgl_pkg.sv @@
// Shared types, constants and codes for the bitmap font glyph layout block.
package bfgl_pkg;

  localparam int GLYPH_COUNT_DEF = 256;
  localparam int COORD_BITS_DEF  = 12;

  localparam int COORD_W = 12;
  localparam int CODE_W  = 8;
  localparam int PEN_W   = 24;
  localparam int LEN_W   = 23;
  localparam int ADV_W   = 13;
  localparam int GAP_W   = 8;
  localparam int PROD_W  = CODE_W + COORD_W;
  localparam int TOP_W   = 21;
  localparam int RIGHT_W = 13;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  localparam logic [CODE_W-1:0] SPACE_CODE   = 8'h20;
  localparam logic [GAP_W-1:0]  CHAR_GAP_RST = 8'd2;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [ADV_W-1:0]   adv_t;
  typedef logic [PROD_W-1:0]  prod_t;

  typedef enum logic [1:0] {
    OP_LAYOUT   = 2'd0,
    OP_LOAD_MAP = 2'd1,
    OP_LOAD_EXT = 2'd2,
    OP_NOP      = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_SPACE,
    KIND_GLYPH
  } kind_e;

  typedef enum logic [2:0] {
    REG_CELL_WIDTH    = 3'd0,
    REG_CELL_HEIGHT   = 3'd1,
    REG_ROW_PITCH     = 3'd2,
    REG_SPACE_ADVANCE = 3'd3,
    REG_CHAR_GAP      = 3'd4,
    REG_PROP_MODE     = 3'd5
  } reg_e;

  typedef struct packed {
    coord_t             cell_width;
    coord_t             cell_height;
    coord_t             row_pitch;
    coord_t             space_advance;
    logic [GAP_W-1:0]   char_gap;
    logic               prop_mode;
  } cfg_t;

  // Classified item handed from the front part to the back part
  typedef struct packed {
    kind_e                    kind;
    logic                     first;
    coord_t                   left;
    coord_t                   wdt;
    adv_t                     adv;
    adv_t                     meas;
    logic [CODE_W-1:0]        j;
    logic signed [PEN_W-1:0]  start_x;
    logic signed [PEN_W-1:0]  dest_y;
  } cmd_t;

  typedef struct packed {
    logic                     glyph_valid;
    coord_t                   src_left;
    logic [TOP_W-1:0]         src_top;
    logic [RIGHT_W-1:0]       src_right;
    logic [TOP_W-1:0]         src_bottom;
    logic signed [PEN_W-1:0]  dest_x;
    logic signed [PEN_W-1:0]  out_y;
    logic [LEN_W-1:0]         measured_length;
  } res_t;

endpackage

@@ sv/bfgl_fifo.sv @@
// Small synchronous FIFO used for the command queue and the result queue.
module bfgl_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ sv/bfgl_regs.sv @@
// APB configuration registers of the glyph layout block.
module bfgl_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bfgl_pkg::ADDR_W-1:0]   paddr,
  input  logic [bfgl_pkg::DATA_W-1:0]   pwdata,
  output logic [bfgl_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output bfgl_pkg::cfg_t                cfg_o
);

  localparam int ADDR_MSB = bfgl_pkg::ADDR_W - 1;

  bfgl_pkg::cfg_t  cfg_q, cfg_d;
  bfgl_pkg::reg_e  sel;
  logic            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign sel    = bfgl_pkg::reg_e'(paddr[ADDR_MSB:2]);
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (sel)
        bfgl_pkg::REG_CELL_WIDTH:    cfg_d.cell_width    = pwdata[bfgl_pkg::COORD_W-1:0];
        bfgl_pkg::REG_CELL_HEIGHT:   cfg_d.cell_height   = pwdata[bfgl_pkg::COORD_W-1:0];
        bfgl_pkg::REG_ROW_PITCH:     cfg_d.row_pitch     = pwdata[bfgl_pkg::COORD_W-1:0];
        bfgl_pkg::REG_SPACE_ADVANCE: cfg_d.space_advance = pwdata[bfgl_pkg::COORD_W-1:0];
        bfgl_pkg::REG_CHAR_GAP:      cfg_d.char_gap      = pwdata[bfgl_pkg::GAP_W-1:0];
        bfgl_pkg::REG_PROP_MODE:     cfg_d.prop_mode     = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (sel)
      bfgl_pkg::REG_CELL_WIDTH:    prdata = bfgl_pkg::DATA_W'(cfg_q.cell_width);
      bfgl_pkg::REG_CELL_HEIGHT:   prdata = bfgl_pkg::DATA_W'(cfg_q.cell_height);
      bfgl_pkg::REG_ROW_PITCH:     prdata = bfgl_pkg::DATA_W'(cfg_q.row_pitch);
      bfgl_pkg::REG_SPACE_ADVANCE: prdata = bfgl_pkg::DATA_W'(cfg_q.space_advance);
      bfgl_pkg::REG_CHAR_GAP:      prdata = bfgl_pkg::DATA_W'(cfg_q.char_gap);
      bfgl_pkg::REG_PROP_MODE:     prdata = bfgl_pkg::DATA_W'(cfg_q.prop_mode);
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{cell_width:    '0,
                 cell_height:   '0,
                 row_pitch:     '0,
                 space_advance: '0,
                 char_gap:      bfgl_pkg::CHAR_GAP_RST,
                 prop_mode:     1'b0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

@@ sv/bfgl_front.sv @@
// Front part: accepts items, runs table loads, looks up map and extents, classifies.
module bfgl_front #(
  parameter int GLYPH_COUNT = bfgl_pkg::GLYPH_COUNT_DEF,
  parameter int COORD_BITS  = bfgl_pkg::COORD_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  bfgl_pkg::cfg_t                       cfg_i,
  input  logic                                 push,
  output logic                                 full,
  input  logic [1:0]                           operation_i,
  input  logic [bfgl_pkg::CODE_W-1:0]          char_code_i,
  input  logic                                 first_char_i,
  input  logic                                 last_char_i,
  input  logic signed [bfgl_pkg::PEN_W-1:0]    start_x_i,
  input  logic signed [bfgl_pkg::PEN_W-1:0]    dest_y_i,
  input  logic [bfgl_pkg::CODE_W-1:0]          table_index_i,
  input  logic [bfgl_pkg::CODE_W-1:0]          map_value_i,
  input  logic [bfgl_pkg::COORD_W-1:0]         extent_offset_i,
  input  logic [bfgl_pkg::COORD_W-1:0]         extent_width_i,
  output logic                                 cmd_push_o,
  output bfgl_pkg::cmd_t                       cmd_o,
  input  logic                                 cmd_full_i
);

  localparam int IW = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
  localparam int CW = (COORD_BITS < bfgl_pkg::COORD_W) ? COORD_BITS : bfgl_pkg::COORD_W;
  localparam int MAP_DEPTH = 1 << bfgl_pkg::CODE_W;
  localparam bfgl_pkg::coord_t CMASK = bfgl_pkg::coord_t'((1 << CW) - 1);
  localparam logic [bfgl_pkg::CODE_W:0] GC = (bfgl_pkg::CODE_W + 1)'(GLYPH_COUNT);

  logic adv, acc;
  bfgl_pkg::op_e in_op;

  // character map: identity until an entry is loaded
  logic [bfgl_pkg::CODE_W-1:0] map_mem [MAP_DEPTH];
  logic [MAP_DEPTH-1:0]        map_vld_q;
  logic [2*CW-1:0]             ext_mem [GLYPH_COUNT];

  // stage 1: map read
  logic                            s1_vld_q;
  bfgl_pkg::op_e                   s1_op_q;
  logic [bfgl_pkg::CODE_W-1:0]     s1_code_q, s1_map_q;
  logic                            s1_mapv_q, s1_first_q, s1_last_q;
  logic signed [bfgl_pkg::PEN_W-1:0] s1_sx_q, s1_dy_q;

  // stage 2: extent read
  logic                            s2_vld_q;
  bfgl_pkg::op_e                   s2_op_q;
  logic [bfgl_pkg::CODE_W-1:0]     s2_code_q, s2_j_q;
  logic                            s2_rng_q, s2_first_q, s2_last_q;
  logic signed [bfgl_pkg::PEN_W-1:0] s2_sx_q, s2_dy_q;
  logic [2*CW-1:0]                 s2_ext_q;

  logic [bfgl_pkg::CODE_W-1:0] s1_j;
  logic                        s1_rng, ld_rng;
  logic [IW-1:0]               ext_addr;
  bfgl_pkg::coord_t            e_off, e_wdt, cell_w;

  assign in_op  = bfgl_pkg::op_e'(operation_i);
  assign adv    = !cmd_full_i;
  assign full   = cmd_full_i;
  assign acc    = push && adv;
  assign ld_rng = ({1'b0, table_index_i} < GC);

  assign s1_j     = s1_mapv_q ? s1_map_q : s1_code_q;
  assign s1_rng   = ({1'b0, s1_j} < GC);
  assign ext_addr = s1_rng ? s1_j[IW-1:0] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_vld_q <= '0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
    end else begin
      if (acc && in_op == bfgl_pkg::OP_LOAD_MAP) begin
        map_vld_q[table_index_i] <= 1'b1;
      end
      if (adv) begin
        s1_vld_q <= acc;
        s2_vld_q <= s1_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && in_op == bfgl_pkg::OP_LOAD_MAP) begin
      map_mem[table_index_i] <= map_value_i;
    end
    if (acc && in_op == bfgl_pkg::OP_LOAD_EXT && ld_rng) begin
      ext_mem[table_index_i[IW-1:0]] <= {extent_width_i[CW-1:0], extent_offset_i[CW-1:0]};
    end
    if (adv) begin
      s1_map_q <= map_mem[char_code_i];
      s2_ext_q <= ext_mem[ext_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_op_q    <= in_op;
      s1_code_q  <= char_code_i;
      s1_mapv_q  <= map_vld_q[char_code_i];
      s1_first_q <= first_char_i;
      s1_last_q  <= last_char_i;
      s1_sx_q    <= start_x_i;
      s1_dy_q    <= dest_y_i;

      s2_op_q    <= s1_op_q;
      s2_code_q  <= s1_code_q;
      s2_j_q     <= s1_j;
      s2_rng_q   <= s1_rng;
      s2_first_q <= s1_first_q;
      s2_last_q  <= s1_last_q;
      s2_sx_q    <= s1_sx_q;
      s2_dy_q    <= s1_dy_q;
    end
  end

  // classification and advance computation
  assign e_off  = s2_rng_q ? bfgl_pkg::coord_t'(s2_ext_q[CW-1:0]) : '0;
  assign e_wdt  = s2_rng_q ? bfgl_pkg::coord_t'(s2_ext_q[2*CW-1:CW]) : '0;
  assign cell_w = cfg_i.cell_width & CMASK;

  always_comb begin
    cmd_o         = '0;
    cmd_o.first   = s2_first_q;
    cmd_o.j       = s2_j_q;
    cmd_o.start_x = s2_sx_q;
    cmd_o.dest_y  = s2_dy_q;
    cmd_o.kind    = bfgl_pkg::KIND_NONE;
    if (s2_op_q == bfgl_pkg::OP_LAYOUT) begin
      if (cfg_i.prop_mode && s2_code_q == bfgl_pkg::SPACE_CODE) begin
        cmd_o.kind = bfgl_pkg::KIND_SPACE;
        cmd_o.adv  = bfgl_pkg::adv_t'(cfg_i.space_advance & CMASK);
        cmd_o.meas = cmd_o.adv;
      end else if (cfg_i.prop_mode) begin
        cmd_o.kind = bfgl_pkg::KIND_GLYPH;
        cmd_o.left = e_off;
        cmd_o.wdt  = e_wdt;
        cmd_o.adv  = bfgl_pkg::adv_t'(e_wdt) + bfgl_pkg::adv_t'(cfg_i.char_gap);
        cmd_o.meas = s2_last_q ? bfgl_pkg::adv_t'(e_wdt) : cmd_o.adv;
      end else begin
        cmd_o.kind = bfgl_pkg::KIND_GLYPH;
        cmd_o.wdt  = cell_w;
        cmd_o.adv  = bfgl_pkg::adv_t'(cell_w);
        cmd_o.meas = cmd_o.adv;
      end
    end
  end

  assign cmd_push_o = s2_vld_q && adv;

endmodule

@@ sv/bfgl_back.sv @@
// Back part: pen and length tracking, source rectangle arithmetic, result hand-off.
module bfgl_back #(
  parameter int COORD_BITS = bfgl_pkg::COORD_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bfgl_pkg::cfg_t  cfg_i,
  input  logic            cmd_empty_i,
  input  bfgl_pkg::cmd_t  cmd_i,
  output logic            cmd_pop_o,
  output logic            res_push_o,
  output bfgl_pkg::res_t  res_o,
  input  logic            res_full_i
);

  localparam int CW = (COORD_BITS < bfgl_pkg::COORD_W) ? COORD_BITS : bfgl_pkg::COORD_W;
  localparam bfgl_pkg::coord_t CMASK = bfgl_pkg::coord_t'((1 << CW) - 1);
  localparam int PW = bfgl_pkg::PEN_W;
  localparam int LW = bfgl_pkg::LEN_W;

  logic [PW-1:0] pen_q, pen_d;
  logic [LW-1:0] len_q, len_d;

  logic                  b1_vld_q;
  bfgl_pkg::kind_e       b1_kind_q;
  bfgl_pkg::coord_t      b1_left_q, b1_wdt_q;
  bfgl_pkg::prod_t       b1_prod_q;
  logic [PW-1:0]         b1_dx_q, b1_dy_q;
  logic [LW-1:0]         b1_len_q;

  logic          layout;
  logic [PW-1:0] pen_base;
  logic [LW-1:0] len_base;
  logic [PW:0]   pen_sum;
  logic [LW:0]   len_sum;
  logic [PW-1:0] pen_new;
  logic [LW-1:0] len_new;
  bfgl_pkg::prod_t prod;
  logic [bfgl_pkg::TOP_W-1:0] top;

  assign res_push_o = b1_vld_q && !res_full_i;
  assign cmd_pop_o  = !cmd_empty_i && (!b1_vld_q || res_push_o);

  // pen and length update for the item being taken from the queue
  assign layout   = (cmd_i.kind != bfgl_pkg::KIND_NONE);
  assign pen_base = cmd_i.first ? cmd_i.start_x : pen_q;
  assign len_base = cmd_i.first ? '0 : len_q;
  assign pen_sum  = {pen_base[PW-1], pen_base} + (PW + 1)'(cmd_i.adv);
  assign len_sum  = {1'b0, len_base} + (LW + 1)'(cmd_i.meas);
  // advances are never negative, so only the upper bound can be crossed
  assign pen_new  = (!pen_sum[PW] && pen_sum[PW-1]) ? {1'b0, {(PW-1){1'b1}}} : pen_sum[PW-1:0];
  assign len_new  = len_sum[LW] ? '1 : len_sum[LW-1:0];
  assign prod     = bfgl_pkg::prod_t'(cmd_i.j) * bfgl_pkg::prod_t'(cfg_i.row_pitch & CMASK);

  always_comb begin
    pen_d = pen_q;
    len_d = len_q;
    if (cmd_pop_o && layout) begin
      pen_d = pen_new;
      len_d = len_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_q    <= '0;
      len_q    <= '0;
      b1_vld_q <= 1'b0;
    end else begin
      pen_q <= pen_d;
      len_q <= len_d;
      if (cmd_pop_o) begin
        b1_vld_q <= 1'b1;
      end else if (res_push_o) begin
        b1_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      b1_kind_q <= cmd_i.kind;
      b1_left_q <= cmd_i.left;
      b1_wdt_q  <= cmd_i.wdt;
      b1_prod_q <= prod;
      b1_dx_q   <= layout ? pen_base : pen_q;
      b1_dy_q   <= cmd_i.dest_y;
      b1_len_q  <= layout ? len_new : len_q;
    end
  end

  // rectangle edges stay inside their field widths, so no clamping is needed
  assign top = bfgl_pkg::TOP_W'(b1_prod_q);

  always_comb begin
    res_o                 = '0;
    res_o.dest_x          = b1_dx_q;
    res_o.out_y           = b1_dy_q;
    res_o.measured_length = b1_len_q;
    if (b1_kind_q == bfgl_pkg::KIND_GLYPH) begin
      res_o.glyph_valid = 1'b1;
      res_o.src_left    = b1_left_q;
      res_o.src_top     = top;
      res_o.src_right   = bfgl_pkg::RIGHT_W'(b1_left_q) + bfgl_pkg::RIGHT_W'(b1_wdt_q);
      res_o.src_bottom  = top + bfgl_pkg::TOP_W'(cfg_i.cell_height & CMASK);
    end
  end

endmodule

@@ sv/bitmap_font_glyph_layout.sv @@
// Top level of the bitmap font glyph layout block.
// Lays out text one character per transaction: operation 0 maps the character through the
// 256-entry map to a glyph row and returns its source rectangle in the font sheet, the pen
// x where it is drawn and the running measured length; operations 1 and 2 load a map entry
// or a glyph extent (offset, width) and return a result with no glyph. The block takes one
// transaction per clock and returns one result per clock in steady state while results are
// popped; the map is read as a transaction is accepted, then extent read, command queue, pen
// update and result queue follow. The rate is bounded by the single pen and length
// accumulate in the back part, which handles one item per cycle while the result queue is
// not full. The map reads as identity until an entry is loaded; extents must be loaded
// before use in proportional mode. Configuration must be written over APB while no
// transaction is in flight; the block itself does not enforce this.
module bitmap_font_glyph_layout #(
  parameter int GLYPH_COUNT = bfgl_pkg::GLYPH_COUNT_DEF,
  parameter int COORD_BITS  = bfgl_pkg::COORD_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [bfgl_pkg::ADDR_W-1:0]          paddr,
  input  logic [bfgl_pkg::DATA_W-1:0]          pwdata,
  output logic [bfgl_pkg::DATA_W-1:0]          prdata,
  output logic                                 pready,
  // items
  input  logic                                 push,
  output logic                                 full,
  input  logic [1:0]                           operation_i,
  input  logic [bfgl_pkg::CODE_W-1:0]          char_code_i,
  input  logic                                 first_char_i,
  input  logic                                 last_char_i,
  input  logic signed [bfgl_pkg::PEN_W-1:0]    start_x_i,
  input  logic signed [bfgl_pkg::PEN_W-1:0]    dest_y_i,
  input  logic [bfgl_pkg::CODE_W-1:0]          table_index_i,
  input  logic [bfgl_pkg::CODE_W-1:0]          map_value_i,
  input  logic [bfgl_pkg::COORD_W-1:0]         extent_offset_i,
  input  logic [bfgl_pkg::COORD_W-1:0]         extent_width_i,
  // results
  output logic                                 empty,
  input  logic                                 pop,
  output logic                                 glyph_valid_o,
  output logic [bfgl_pkg::COORD_W-1:0]         src_left_o,
  output logic [bfgl_pkg::TOP_W-1:0]           src_top_o,
  output logic [bfgl_pkg::RIGHT_W-1:0]         src_right_o,
  output logic [bfgl_pkg::TOP_W-1:0]           src_bottom_o,
  output logic signed [bfgl_pkg::PEN_W-1:0]    dest_x_o,
  output logic signed [bfgl_pkg::PEN_W-1:0]    out_y_o,
  output logic [bfgl_pkg::LEN_W-1:0]           measured_length_o
);

  bfgl_pkg::cfg_t cfg;
  bfgl_pkg::cmd_t cmd_in, cmd_out;
  bfgl_pkg::res_t res_in, res_out;
  logic cmd_push, cmd_full, cmd_pop, cmd_empty;
  logic res_push, res_full;

  bfgl_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bfgl_front #(
    .GLYPH_COUNT (GLYPH_COUNT),
    .COORD_BITS  (COORD_BITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .push            (push),
    .full            (full),
    .operation_i     (operation_i),
    .char_code_i     (char_code_i),
    .first_char_i    (first_char_i),
    .last_char_i     (last_char_i),
    .start_x_i       (start_x_i),
    .dest_y_i        (dest_y_i),
    .table_index_i   (table_index_i),
    .map_value_i     (map_value_i),
    .extent_offset_i (extent_offset_i),
    .extent_width_i  (extent_width_i),
    .cmd_push_o      (cmd_push),
    .cmd_o           (cmd_in),
    .cmd_full_i      (cmd_full)
  );

  bfgl_fifo #(
    .WIDTH ($bits(bfgl_pkg::cmd_t)),
    .DEPTH (4)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  bfgl_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .res_full_i  (res_full)
  );

  bfgl_fifo #(
    .WIDTH ($bits(bfgl_pkg::res_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign glyph_valid_o     = res_out.glyph_valid;
  assign src_left_o        = res_out.src_left;
  assign src_top_o         = res_out.src_top;
  assign src_right_o       = res_out.src_right;
  assign src_bottom_o      = res_out.src_bottom;
  assign dest_x_o          = res_out.dest_x;
  assign out_y_o           = res_out.out_y;
  assign measured_length_o = res_out.measured_length;

endmodule
